// File: src/mmf_pkg.sv
// Shared types, widths and codes of the fixed-point matrix multiplier.
package mmf_pkg;

  localparam int unsigned MaxDimDefault = 8;
  localparam int unsigned DimW          = 4;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned FuncW         = 2;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned ElemW         = 16;
  localparam int unsigned ProdW         = 2 * ElemW;
  localparam int unsigned SumW          = 35;

  localparam logic [DimW-1:0] DimReset = 4'd8;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } mmf_func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COLS_B     = 2'd2
  } mmf_cfg_e;

  // Bookkeeping that travels with each memory read through the MAC pipeline.
  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            first_k;
    logic            last_k;
    logic            last_elem;
  } mmf_tag_t;

  // Address width of a memory of the given depth, at least one bit.
  function automatic int unsigned mmf_addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: src/mmf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mmf_ram
  import mmf_pkg::*;
#(
  parameter int unsigned WIDTH = ElemW,
  parameter int unsigned DEPTH = MaxDimDefault * MaxDimDefault
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [mmf_addr_w(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic [mmf_addr_w(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mmf_mac.sv
// Two-stage multiply-accumulate unit that forms one dot product per tagged run.
module mmf_mac
  import mmf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  mmf_tag_t                tag_i,
  input  logic signed [ElemW-1:0] a_i,
  input  logic signed [ElemW-1:0] b_i,
  output logic                    res_vld_o,
  output mmf_tag_t                res_tag_o,
  output logic signed [SumW-1:0]  res_sum_o
);

  logic                    vld1_q;
  mmf_tag_t                tag1_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [SumW-1:0]  acc_q, acc_d;
  logic signed [SumW-1:0]  prod_ext;
  logic                    res_vld_q;
  mmf_tag_t                res_tag_q;

  assign prod_d   = a_i * b_i;
  assign prod_ext = {{(SumW - ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (vld1_q) begin
      acc_d = tag1_q.first_k ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      vld1_q    <= vld_i;
      res_vld_q <= vld1_q & tag1_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      prod_q <= prod_d;
      tag1_q <= tag_i;
    end
    acc_q <= acc_d;
    if (vld1_q) begin
      res_tag_q <= tag1_q;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_tag_o = res_tag_q;
  assign res_sum_o = acc_q;

endmodule

// File: src/matrix_multiply_fixed.sv
// Top level of the fixed-point matrix multiplier: stores, sequencer and output register.
//
//   Channel  Direction  Handshake                Payload
//   in       sink       in_valid_i / in_stall_o  func, row_index, col_index, element_value
//   out      source     out_valid_o / out_stall_i out_row, out_col, product_value, last_flag
//   cfg      sink       cfg_we_i                 cfg_index_i, cfg_data_i
//
// A load request writes one entry of the A or B store.
// A compute request holds off the input (in_stall_o high) until its last sum is formed.
// For each element the sequencer issues one read per inner step, then waits while the read,
// multiply and accumulate stages drain.
// Reset clears control state only; the stores hold garbage until written.
// A stalled result holds in the output register and delays the next element's first read.
module matrix_multiply_fixed
  import mmf_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [DimW-1:0]         cfg_data_i,
  // Input request channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FuncW-1:0]        func_i,
  input  logic [IdxW-1:0]         row_index_i,
  input  logic [IdxW-1:0]         col_index_i,
  input  logic signed [ElemW-1:0] element_value_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IdxW-1:0]         out_row_o,
  output logic [IdxW-1:0]         out_col_o,
  output logic signed [SumW-1:0]  product_value_o,
  output logic                    last_flag_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = mmf_addr_w(Depth);
  localparam logic [DimW-1:0]  MaxDimD = DimW'(MAX_DIM);
  localparam logic [AddrW-1:0] MaxDimA = AddrW'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } mmf_state_e;

  // Configuration registers.
  logic [DimW-1:0] rows_a_q, inner_size_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= DimReset;
      inner_size_q <= DimReset;
      cols_b_q     <= DimReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS_A:     rows_a_q     <= cfg_data_i;
        CFG_INNER_SIZE: inner_size_q <= cfg_data_i;
        CFG_COLS_B:     cols_b_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero counts as one, anything above the store size is clamped.
  logic [DimW-1:0] nr, nk, nc;

  always_comb begin
    nr = rows_a_q;
    nk = inner_size_q;
    nc = cols_b_q;
    if (nr == '0) nr = DimW'(1);
    if (nk == '0) nk = DimW'(1);
    if (nc == '0) nc = DimW'(1);
    if (nr > MaxDimD) nr = MaxDimD;
    if (nk > MaxDimD) nk = MaxDimD;
    if (nc > MaxDimD) nc = MaxDimD;
  end

  // Sequencer state and loop counters.
  mmf_state_e      state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            out_valid_q, out_valid_d;

  logic in_accept, in_load, load_ok, we_a, we_b;
  logic issue, k_last, i_last, j_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Loads outside the store are dropped; loads beyond the current sizes are kept.
  assign load_ok = ({1'b0, row_index_i} < MaxDimD) && ({1'b0, col_index_i} < MaxDimD);
  assign in_load = in_accept & load_ok;
  assign we_a    = in_load & (func_i == FUNC_LOAD_A);
  assign we_b    = in_load & (func_i == FUNC_LOAD_B);

  assign k_last = ({1'b0, k_q} == nk - DimW'(1));
  assign i_last = ({1'b0, i_q} == nr - DimW'(1));
  assign j_last = ({1'b0, j_q} == nc - DimW'(1));

  // The first read of an element waits until the output register will be free.
  assign issue = (state_q == ST_ISSUE) &&
                 ((k_q != '0) || !out_valid_q || !out_stall_i);

  // MAC pipeline result.
  logic                   res_vld;
  mmf_tag_t               res_tag;
  logic signed [SumW-1:0] res_sum;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (func_i == FUNC_COMPUTE)) begin
          state_d = ST_ISSUE;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (issue) begin
          if (k_last) begin
            state_d = ST_DRAIN;
            k_d     = '0;
          end else begin
            k_d = k_q + IdxW'(1);
          end
        end
      end
      ST_DRAIN: begin
        // Wait for the element's sum to land in the output register.
        if (res_vld) begin
          if (i_last && j_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + IdxW'(1);
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Store addresses: loads write row-major, the sequencer reads A[i][k] and B[k][j].
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;

  assign waddr   = AddrW'(row_index_i) * MaxDimA + AddrW'(col_index_i);
  assign raddr_a = AddrW'(i_q) * MaxDimA + AddrW'(k_q);
  assign raddr_b = AddrW'(k_q) * MaxDimA + AddrW'(j_q);

  logic [ElemW-1:0] rdata_a, rdata_b;

  mmf_ram #(
    .WIDTH (ElemW),
    .DEPTH (Depth)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mmf_ram #(
    .WIDTH (ElemW),
    .DEPTH (Depth)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // The tag is registered once behind the read, lining up with the registered read data.
  logic     rd_vld_q;
  mmf_tag_t rd_tag_q, rd_tag_d;

  always_comb begin
    rd_tag_d.row       = i_q;
    rd_tag_d.col       = j_q;
    rd_tag_d.first_k   = (k_q == '0);
    rd_tag_d.last_k    = k_last;
    rd_tag_d.last_elem = i_last & j_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_tag_q <= rd_tag_d;
    end
  end

  mmf_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (rd_vld_q),
    .tag_i     (rd_tag_q),
    .a_i       (rdata_a),
    .b_i       (rdata_b),
    .res_vld_o (res_vld),
    .res_tag_o (res_tag),
    .res_sum_o (res_sum)
  );

  // Output register: loaded by a finished sum, emptied when the result is taken.
  logic [IdxW-1:0]        out_row_q, out_col_q;
  logic signed [SumW-1:0] out_sum_q;
  logic                   out_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_vld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_row_q  <= res_tag.row;
      out_col_q  <= res_tag.col;
      out_sum_q  <= res_sum;
      out_last_q <= res_tag.last_elem;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_sum_q;
  assign last_flag_o     = out_last_q;

`ifndef ASSERT_OFF
  // A finished sum never lands on a result that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> !(out_valid_q && out_stall_i))
    else $error("finished sum overwrote a pending result");

  // Sums only complete while the sequencer waits for them.
  a_res_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> (state_q == ST_DRAIN))
    else $error("sum completed outside the drain phase");

  // Reads in flight always belong to an active compute request.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q != ST_IDLE))
    else $error("store read in flight while idle");
`endif

endmodule

// File: tb/matrix_multiply_fixed_tb.sv
// Self-checking testbench of the fixed-point matrix multiplier.
module matrix_multiply_fixed_tb;
  import mmf_pkg::*;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned MaxDim       = MaxDimDefault;
  localparam int unsigned Entries      = MaxDim * MaxDim;
  // A quiet stretch of this length means the block has drained.
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned TargetItems  = 280;
  localparam int unsigned LimitCycles  = 2_000_000;
  // The fourth function code has no meaning and must be dropped by the block.
  localparam logic [FuncW-1:0] FuncReserved = 2'd3;

  // One expected element of the product, in the order the block emits them.
  typedef struct packed {
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic signed [SumW-1:0] value;
    logic                   last;
  } product_elem_t;

  // One row of the directed table: either a register write or a request.
  // Where typed is set, the single 1x1 product is given by hand.
  typedef struct packed {
    logic                   is_cfg;
    logic [CfgIdxW-1:0]     reg_sel;
    logic [DimW-1:0]        reg_val;
    logic [FuncW-1:0]       func;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic [ElemW-1:0]       elem;
    logic                   typed;
    logic signed [SumW-1:0] typed_value;
  } step_t;

  localparam int unsigned NumSteps = 21;

  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index_i     = '0;
  logic [DimW-1:0]         cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [FuncW-1:0]        func_i          = '0;
  logic [IdxW-1:0]         row_index_i     = '0;
  logic [IdxW-1:0]         col_index_i     = '0;
  logic signed [ElemW-1:0] element_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [IdxW-1:0]         out_row_o;
  logic [IdxW-1:0]         out_col_o;
  logic signed [SumW-1:0]  product_value_o;
  logic                    last_flag_o;

  // Shadow copy of the block: both stores, which entries have been written,
  // and the three size registers as last written.
  logic signed [ElemW-1:0] a_store [Entries];
  logic signed [ElemW-1:0] b_store [Entries];
  bit                      a_loaded [Entries];
  bit                      b_loaded [Entries];
  logic [DimW-1:0]         rows_reg, inner_reg, cols_reg;

  product_elem_t product_queue [$];
  int unsigned   mismatch_count = 0;
  int unsigned   requests_sent  = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  step_t         steps [NumSteps];

  matrix_multiply_fixed i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .product_value_o(product_value_o),
    .last_flag_o    (last_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // A size of zero acts as one, and anything above the store size acts as
  // the store size.
  function automatic int unsigned clamp_dim(input logic [DimW-1:0] d);
    if (d == '0) return 1;
    if (d > MaxDim) return MaxDim;
    return d;
  endfunction

  // Element values lean toward the two extremes of Q8.8 so that the widest
  // sums show up often.
  function automatic logic [ElemW-1:0] pick_element();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return ElemW'($urandom_range(511)) - 16'd256;
      default: return ElemW'($urandom);
    endcase
  endfunction

  // Mostly small sizes keep the run short; zero and oversize values still
  // come up now and then.
  function automatic logic [DimW-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return DimW'($urandom_range(15, 9));
    if (r < 24) return DimW'($urandom_range(8, 5));
    return DimW'($urandom_range(4, 1));
  endfunction

  // Applies one accepted request to the shadow. A load fills one store entry;
  // a compute queues every element of the product in row-major order, each
  // an exact dot product truncated to the output width.
  task automatic shadow_request(input logic [FuncW-1:0] func,
                                input logic [IdxW-1:0] row, input logic [IdxW-1:0] col,
                                input logic [ElemW-1:0] elem);
    int unsigned   nr, nk, nc, addr;
    longint        acc;
    product_elem_t pe;
    addr = row * MaxDim + col;
    case (func)
      FUNC_LOAD_A: begin
        a_store[addr]  = elem;
        a_loaded[addr] = 1'b1;
      end
      FUNC_LOAD_B: begin
        b_store[addr]  = elem;
        b_loaded[addr] = 1'b1;
      end
      FUNC_COMPUTE: begin
        nr = clamp_dim(rows_reg);
        nk = clamp_dim(inner_reg);
        nc = clamp_dim(cols_reg);
        for (int unsigned i = 0; i < nr; i++) begin
          for (int unsigned j = 0; j < nc; j++) begin
            acc = 0;
            for (int unsigned k = 0; k < nk; k++) begin
              acc += longint'(a_store[i * MaxDim + k]) * longint'(b_store[k * MaxDim + j]);
            end
            pe.row   = IdxW'(i);
            pe.col   = IdxW'(j);
            pe.value = acc[SumW-1:0];
            pe.last  = (i == nr - 1) && (j == nc - 1);
            product_queue.push_back(pe);
          end
        end
      end
      default: begin
        // The reserved code leaves everything as it was.
      end
    endcase
  endtask

  // Presents one request and returns at the clock edge that accepts it.
  // Valid is only lowered during a gap, never dropped between back-to-back
  // requests, and the payload holds while the block stalls.
  task automatic send_request(input logic [FuncW-1:0] func,
                              input logic [IdxW-1:0] row, input logic [IdxW-1:0] col,
                              input logic [ElemW-1:0] elem);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    func_i          = func;
    row_index_i     = row;
    col_index_i     = col;
    element_value_i = elem;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (func != FuncReserved) requests_sent++;
  endtask

  // Holds off the input side until every queued product element has come
  // back, then lets the block settle so a register write lands while idle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (product_queue.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_dim(input mmf_cfg_e sel, input logic [DimW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (sel)
      CFG_ROWS_A:     rows_reg  = val;
      CFG_INNER_SIZE: inner_reg = val;
      CFG_COLS_B:     cols_reg  = val;
      default: ;
    endcase
  endtask

  // The receiver stalls at random, at a rate set per phase.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  // Every accepted result is checked against the oldest expected element.
  always @(posedge clk_i) begin
    product_elem_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (product_queue.size() == 0) begin
        $error("unexpected product element: row %0d col %0d value %0d",
               out_row_o, out_col_o, product_value_o);
        mismatch_count++;
      end else begin
        want = product_queue.pop_front();
        if (out_row_o !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row_o);
          mismatch_count++;
        end
        if (out_col_o !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col_o);
          mismatch_count++;
        end
        if (product_value_o !== want.value) begin
          $error("product_value: expected %0d, got %0d", $signed(want.value),
                 product_value_o);
          mismatch_count++;
        end
        if (last_flag_o !== want.last) begin
          $error("last_flag: expected %0d, got %0d", want.last, last_flag_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    product_elem_t   pe;
    int unsigned     phase, nr, nk, nc, burst, r;
    logic [IdxW-1:0] row, col;
    logic [DimW-1:0] d_rows, d_inner, d_cols;

    // Directed table. Register rows wait for the block to go idle first.
    // The 1x1 products of the Q8.8 extremes are typed in by hand; the rest
    // are worked out by the shadow. The last part checks that a size of zero
    // acts as one and that loads outside the current sizes are kept.
    //          cfg   reg             val    func          row   col   elem
    //          typed value
    steps = '{
      '{1'b1, CFG_ROWS_A,     4'd1, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b1, CFG_INNER_SIZE, 4'd1, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b1, CFG_COLS_B,     4'd1, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_A,  3'd0, 3'd0, 16'h8000, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_B,  3'd0, 3'd0, 16'h8000, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1,
        35'sd1073741824},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_A,  3'd0, 3'd0, 16'h7fff, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1,
        -35'sd1073709056},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_B,  3'd0, 3'd0, 16'h7fff, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1,
        35'sd1073676289},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FuncReserved, 3'd7, 3'd7, 16'hffff, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_B,  3'd7, 3'd7, 16'h8000, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_A,  3'd7, 3'd7, 16'h7fff, 1'b0, 35'sd0},
      '{1'b1, CFG_ROWS_A,     4'd0, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b1, CFG_INNER_SIZE, 4'd0, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b1, CFG_COLS_B,     4'd2, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_B,  3'd0, 3'd1, 16'h0100, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_LOAD_A,  3'd0, 3'd0, 16'h0200, 1'b0, 35'sd0},
      '{1'b0, CFG_ROWS_A,     4'd0, FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, 35'sd0}
    };

    // Reset puts the size registers at their reset value and leaves the
    // stores unwritten.
    rows_reg  = DimReset;
    inner_reg = DimReset;
    cols_reg  = DimReset;
    for (int unsigned e = 0; e < Entries; e++) begin
      a_store[e]  = '0;
      b_store[e]  = '0;
      a_loaded[e] = 1'b0;
      b_loaded[e] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (steps[s]) begin
      if (steps[s].is_cfg) begin
        wait_idle();
        write_dim(mmf_cfg_e'(steps[s].reg_sel), steps[s].reg_val);
      end else begin
        send_request(steps[s].func, steps[s].row, steps[s].col, steps[s].elem);
        if (steps[s].typed) begin
          pe = '{row: '0, col: '0, value: steps[s].typed_value, last: 1'b1};
          product_queue.push_back(pe);
        end else begin
          shadow_request(steps[s].func, steps[s].row, steps[s].col, steps[s].elem);
        end
      end
    end

    // Random part. Each phase drains the block, picks an idle pattern and
    // new sizes, sends a burst of loads and some noise, fills in whatever
    // store entries the product will read that were never written, and then
    // asks for the product once or twice. The drain at the start of every
    // phase is also the point where the sender sits still until every
    // result has come back.
    phase = 0;
    while (requests_sent < TargetItems) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // A few phases pin the sizes to their extremes; the largest product
      // only comes up a couple of times since it is slow.
      case (phase)
        3:       begin d_rows = 4'd8;  d_inner = 4'd8;  d_cols = 4'd8;  end
        6:       begin d_rows = 4'd0;  d_inner = 4'd0;  d_cols = 4'd0;  end
        9:       begin d_rows = 4'd15; d_inner = 4'd15; d_cols = 4'd15; end
        12:      begin d_rows = 4'd1;  d_inner = 4'd15; d_cols = 4'd1;  end
        default: begin d_rows = pick_dim(); d_inner = pick_dim(); d_cols = pick_dim(); end
      endcase
      write_dim(CFG_ROWS_A, d_rows);
      write_dim(CFG_INNER_SIZE, d_inner);
      write_dim(CFG_COLS_B, d_cols);
      nr = clamp_dim(rows_reg);
      nk = clamp_dim(inner_reg);
      nc = clamp_dim(cols_reg);

      burst = $urandom_range(10, 2);
      for (int unsigned b = 0; b < burst; b++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          send_request(FuncReserved, IdxW'($urandom), IdxW'($urandom), ElemW'($urandom));
        end else if (r < 55) begin
          // Most loads land inside the current sizes, the rest anywhere.
          row = ($urandom_range(9) < 7) ? IdxW'($urandom_range(nr - 1)) : IdxW'($urandom);
          col = ($urandom_range(9) < 7) ? IdxW'($urandom_range(nk - 1)) : IdxW'($urandom);
          send_request(FUNC_LOAD_A, row, col, pick_element());
          shadow_request(FUNC_LOAD_A, row, col, element_value_i);
        end else begin
          row = ($urandom_range(9) < 7) ? IdxW'($urandom_range(nk - 1)) : IdxW'($urandom);
          col = ($urandom_range(9) < 7) ? IdxW'($urandom_range(nc - 1)) : IdxW'($urandom);
          send_request(FUNC_LOAD_B, row, col, pick_element());
          shadow_request(FUNC_LOAD_B, row, col, element_value_i);
        end
      end

      // The product must never read an entry that was never written.
      for (int unsigned i = 0; i < nr; i++) begin
        for (int unsigned k = 0; k < nk; k++) begin
          if (!a_loaded[i * MaxDim + k]) begin
            send_request(FUNC_LOAD_A, IdxW'(i), IdxW'(k), pick_element());
            shadow_request(FUNC_LOAD_A, IdxW'(i), IdxW'(k), element_value_i);
          end
        end
      end
      for (int unsigned k = 0; k < nk; k++) begin
        for (int unsigned j = 0; j < nc; j++) begin
          if (!b_loaded[k * MaxDim + j]) begin
            send_request(FUNC_LOAD_B, IdxW'(k), IdxW'(j), pick_element());
            shadow_request(FUNC_LOAD_B, IdxW'(k), IdxW'(j), element_value_i);
          end
        end
      end

      // A second product right behind the first checks that the block takes
      // a new compute request straight after the last element of the old one.
      burst = $urandom_range(2, 1);
      for (int unsigned b = 0; b < burst; b++) begin
        send_request(FUNC_COMPUTE, IdxW'($urandom), IdxW'($urandom), ElemW'($urandom));
        shadow_request(FUNC_COMPUTE, '0, '0, '0);
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("Verification failed");
    $finish;
  end

endmodule
